@@ design/pdc_pkg.sv @@
package pdc_pkg;

	localparam int ZW = 24;
	localparam int STEPW = 20;
	localparam int FEEDW = 16;
	localparam int ACCW = 25;
	localparam int CNTW = 5;
	localparam int PCW = 4;
	localparam int IDXW = 3;

	localparam logic [CNTW-1:0] MAX_PECKS = 5'd20;
	localparam logic signed [ZW-1:0] ZMAX = 24'sd8388607;
	localparam logic signed [ZW:0] SAFE_CLEAR = 25'sd5000;
	localparam logic signed [ZW:0] PECK_CLEAR = 25'sd1000;
	localparam logic [STEPW-1:0] MIN_PECK = 20'd500;
	localparam logic [FEEDW-1:0] RAPID_FEED = 16'd5000;

	localparam logic signed [ZW-1:0] RST_Z_TOP = 24'sd0;
	localparam logic signed [ZW-1:0] RST_Z_BOTTOM = -24'sd1000;
	localparam logic [STEPW-1:0] RST_PECK_STEP = 20'd1000;
	localparam logic [FEEDW-1:0] RST_FEED_Z = 16'd100;

	typedef enum logic [IDXW-1:0] {
		REG_Z_TOP = 3'd0,
		REG_Z_BOTTOM = 3'd1,
		REG_PECK_STEP = 3'd2,
		REG_FEED_Z = 3'd3,
		REG_PECK_MODE = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [ZW-1:0] hole_x;
		logic signed [ZW-1:0] hole_y;
		logic first_hole;
	} in_item_t;

	typedef struct packed {
		logic signed [ZW-1:0] move_x;
		logic signed [ZW-1:0] move_y;
		logic signed [ZW-1:0] move_z;
		logic is_cut;
		logic [FEEDW-1:0] move_feed;
		logic last_move;
		logic bad_config;
	} out_item_t;

	typedef enum logic [PCW-1:0] {
		ST_WAIT = 4'd0,
		ST_INIT = 4'd1,
		ST_REPO = 4'd2,
		ST_CLEAR = 4'd3,
		ST_PLUNGE = 4'd4,
		ST_RETRACT = 4'd5,
		ST_ERR = 4'd6,
		ST_CUT = 4'd7,
		ST_BACK = 4'd8
	} step_t;

	typedef enum logic [2:0] {
		ZS_ZERO = 3'd0,
		ZS_SAFE = 3'd1,
		ZS_CLEAR = 3'd2,
		ZS_NEXT = 3'd3,
		ZS_BOTTOM = 3'd4
	} zsrc_t;

	typedef enum logic [1:0] {
		LM_NEVER = 2'd0,
		LM_ALWAYS = 2'd1,
		LM_IF_DONE = 2'd2
	} last_mode_t;

	typedef enum logic [2:0] {
		JM_NEXT = 3'd0,
		JM_DISPATCH = 3'd1,
		JM_MODE = 3'd2,
		JM_LOOP = 3'd3
	} jump_t;

	typedef struct packed {
		logic emit;
		logic cut;
		logic err;
		logic peck_upd;
		zsrc_t zsrc;
		last_mode_t last;
		jump_t jump;
		step_t next;
	} ctrl_t;

	function automatic ctrl_t ucode(input step_t pc);
		ctrl_t cw;
		cw = '{emit: 1'b0, cut: 1'b0, err: 1'b0, peck_upd: 1'b0, zsrc: ZS_ZERO,
			last: LM_NEVER, jump: JM_NEXT, next: ST_WAIT};
		case (pc)
			ST_WAIT: begin
				cw.jump = JM_DISPATCH;
			end
			ST_INIT: begin
				cw.emit = 1'b1;
				cw.zsrc = ZS_SAFE;
				cw.next = ST_REPO;
			end
			ST_REPO: begin
				cw.emit = 1'b1;
				cw.zsrc = ZS_SAFE;
				cw.jump = JM_MODE;
			end
			ST_CLEAR: begin
				cw.emit = 1'b1;
				cw.zsrc = ZS_CLEAR;
				cw.next = ST_PLUNGE;
			end
			ST_PLUNGE: begin
				cw.emit = 1'b1;
				cw.cut = 1'b1;
				cw.peck_upd = 1'b1;
				cw.zsrc = ZS_NEXT;
				cw.next = ST_RETRACT;
			end
			ST_RETRACT: begin
				cw.emit = 1'b1;
				cw.zsrc = ZS_SAFE;
				cw.last = LM_IF_DONE;
				cw.jump = JM_LOOP;
			end
			ST_ERR: begin
				cw.emit = 1'b1;
				cw.err = 1'b1;
				cw.last = LM_ALWAYS;
			end
			ST_CUT: begin
				cw.emit = 1'b1;
				cw.cut = 1'b1;
				cw.zsrc = ZS_BOTTOM;
				cw.next = ST_BACK;
			end
			ST_BACK: begin
				cw.emit = 1'b1;
				cw.zsrc = ZS_SAFE;
				cw.last = LM_ALWAYS;
			end
			default: begin
				cw.next = ST_WAIT;
			end
		endcase
		return cw;
	endfunction

endpackage

@@ design/peck_drill_cycle_generator.sv @@
// Channel  | Direction | Handshake             | Payload
// in       | input     | in_valid / in_stall   | in_data (hole_x, hole_y, first_hole)
// out      | output    | out_valid / out_stall | out_data (one move per transfer)
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Bad config gives one error move; else a hole gives an init move (first hole only), then
// a repo, cut and back move in plain mode, or a repo and per peck clear, plunge, retract.
// The sequencer emits one move per control step after dispatch into a single output register.
// Stalls on the output hold the step counter; in_stall is high while a hole is in work.
// arst_n clears the step counter, output valid and the config registers to their reset values.
module peck_drill_cycle_generator (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  pdc_pkg::in_item_t       in_data,
	output logic                    out_valid,
	input  logic                    out_stall,
	output pdc_pkg::out_item_t      out_data,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [pdc_pkg::IDXW-1:0] cfg_index,
	input  logic [pdc_pkg::ZW-1:0]  cfg_data
);
	import pdc_pkg::*;

	logic signed [ZW-1:0] z_top_q;
	logic signed [ZW-1:0] z_bottom_q;
	logic [STEPW-1:0] peck_step_q;
	logic [FEEDW-1:0] feed_z_q;
	logic peck_mode_q;

	step_t pc_q;
	ctrl_t cw;
	logic signed [ZW-1:0] x_q;
	logic signed [ZW-1:0] y_q;
	logic signed [ZW-1:0] zcur_q;
	logic [ACCW-1:0] acc_q;
	logic [CNTW-1:0] cnt_q;
	logic more_q;
	logic out_valid_q;
	out_item_t out_data_q;

	logic in_acc;
	logic advance;
	logic bad_cfg;
	logic more;
	logic [STEPW-1:0] step_eff;
	logic [ACCW-1:0] depth;
	logic signed [ZW:0] safe_sum;
	logic signed [ZW:0] clear_sum;
	logic signed [ZW-1:0] safe_z;
	logic signed [ZW-1:0] clear_z;
	logic signed [ZW+1:0] peck_z;
	logic signed [ZW-1:0] next_z;
	logic signed [ZW-1:0] emit_z;
	logic emit_last;
	out_item_t emit_item;
	step_t next_pc;

	assign cfg_ready = 1'b1;
	assign cw = ucode(pc_q);
	assign in_stall = (pc_q != ST_WAIT);
	assign in_acc = in_valid && !in_stall;
	assign advance = !cw.emit || !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	assign bad_cfg = (z_top_q <= z_bottom_q);
	assign step_eff = (peck_step_q < MIN_PECK) ? MIN_PECK : peck_step_q;
	assign depth = ACCW'({z_top_q[ZW-1], z_top_q} - {z_bottom_q[ZW-1], z_bottom_q});
	assign safe_sum = {z_top_q[ZW-1], z_top_q} + SAFE_CLEAR;
	assign clear_sum = {zcur_q[ZW-1], zcur_q} + PECK_CLEAR;
	assign safe_z = (safe_sum > ZW'(ZMAX)) ? ZMAX : safe_sum[ZW-1:0];
	assign clear_z = (clear_sum > ZW'(ZMAX)) ? ZMAX : clear_sum[ZW-1:0];
	assign more = (acc_q < depth) && (cnt_q < MAX_PECKS);
	assign peck_z = {{2{z_top_q[ZW-1]}}, z_top_q} - $signed({1'b0, acc_q});
	assign next_z = more ? peck_z[ZW-1:0] : z_bottom_q;

	always_comb begin
		case (cw.zsrc)
			ZS_SAFE: emit_z = safe_z;
			ZS_CLEAR: emit_z = clear_z;
			ZS_NEXT: emit_z = next_z;
			ZS_BOTTOM: emit_z = z_bottom_q;
			default: emit_z = '0;
		endcase
		case (cw.last)
			LM_ALWAYS: emit_last = 1'b1;
			LM_IF_DONE: emit_last = !more_q;
			default: emit_last = 1'b0;
		endcase
		emit_item.move_x = cw.err ? '0 : x_q;
		emit_item.move_y = cw.err ? '0 : y_q;
		emit_item.move_z = emit_z;
		emit_item.is_cut = cw.cut;
		emit_item.move_feed = cw.err ? '0 : (cw.cut ? feed_z_q : RAPID_FEED);
		emit_item.last_move = emit_last;
		emit_item.bad_config = cw.err;
	end

	always_comb begin
		case (cw.jump)
			JM_DISPATCH: begin
				if (!in_acc) begin
					next_pc = ST_WAIT;
				end else if (bad_cfg) begin
					next_pc = ST_ERR;
				end else if (in_data.first_hole) begin
					next_pc = ST_INIT;
				end else begin
					next_pc = ST_REPO;
				end
			end
			JM_MODE: next_pc = peck_mode_q ? ST_CLEAR : ST_CUT;
			JM_LOOP: next_pc = more_q ? ST_CLEAR : ST_WAIT;
			default: next_pc = cw.next;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_top_q <= RST_Z_TOP;
			z_bottom_q <= RST_Z_BOTTOM;
			peck_step_q <= RST_PECK_STEP;
			feed_z_q <= RST_FEED_Z;
			peck_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_Z_TOP: z_top_q <= cfg_data;
				REG_Z_BOTTOM: z_bottom_q <= cfg_data;
				REG_PECK_STEP: peck_step_q <= cfg_data[STEPW-1:0];
				REG_FEED_Z: feed_z_q <= cfg_data[FEEDW-1:0];
				REG_PECK_MODE: peck_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pc_q <= next_pc;
			end
			if (cw.emit && advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= in_data.hole_x;
			y_q <= in_data.hole_y;
			zcur_q <= z_top_q;
			acc_q <= ACCW'(step_eff);
			cnt_q <= CNTW'(1);
		end else if (cw.peck_upd && advance) begin
			zcur_q <= next_z;
			acc_q <= acc_q + ACCW'(step_eff);
			cnt_q <= cnt_q + CNTW'(1);
			more_q <= more;
		end
		if (cw.emit && advance) begin
			out_data_q <= emit_item;
		end
	end

endmodule

@@ design/pdc_checker.sv @@
module pdc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input pdc_pkg::out_item_t out_data
);
	import pdc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again before the hole was finished");

	a_busy_mid_hole: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_move |-> in_stall)
		else $error("input taken in the middle of a move list");

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_config |-> out_data.last_move && !out_data.is_cut)
		else $error("error result is malformed");

	a_rapid_feed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_cut && !out_data.bad_config |->
			out_data.move_feed == RAPID_FEED)
		else $error("rapid move with wrong feed");

endmodule

bind peck_drill_cycle_generator pdc_checker u_pdc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);
